// ===== hdl/gosos_pkg.sv =====
// Shared types and constants for the GEMM output scale/offset/saturate stage.
// Used by every module of the block; no dependencies.
package gosos_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// two products plus a shifted offset: two bits of growth over a product
	localparam int SUM_W     = PROD_W + 2;
	localparam int QUOT_W    = SUM_W - FRAC_BITS;
	localparam int IDX_W     = 2;

	// offset_mode codes
	localparam logic [1:0] OFS_NONE  = 2'd0;
	localparam logic [1:0] OFS_FIXED = 2'd1;
	localparam logic [1:0] OFS_COL   = 2'd2;
	localparam logic [1:0] OFS_ROW   = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_OFFSET_MODE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA_SCALE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_BETA_SCALE   = 2'd2;
	localparam logic [IDX_W-1:0] REG_FIXED_OFFSET = 2'd3;

	localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;

	typedef struct packed {
		logic [1:0]               offset_mode;
		logic signed [DATA_W-1:0] alpha_scale;
		logic signed [DATA_W-1:0] beta_scale;
		logic signed [DATA_W-1:0] fixed_offset;
	} cfg_t;

endpackage

// ===== hdl/gosos_cfg.sv =====
// Configuration register file of the output stage.
// Depends on gosos_pkg.
module gosos_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gosos_pkg::IDX_W-1:0]       cfg_index,
	input  logic [gosos_pkg::DATA_W-1:0]      cfg_data,
	output gosos_pkg::cfg_t                   cfg
);

	gosos_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_mode  <= gosos_pkg::OFS_NONE;
			cfg_q.alpha_scale  <= gosos_pkg::ALPHA_RESET;
			cfg_q.beta_scale   <= '0;
			cfg_q.fixed_offset <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gosos_pkg::REG_OFFSET_MODE:  cfg_q.offset_mode  <= cfg_data[1:0];
				gosos_pkg::REG_ALPHA_SCALE:  cfg_q.alpha_scale  <= cfg_data;
				gosos_pkg::REG_BETA_SCALE:   cfg_q.beta_scale   <= cfg_data;
				gosos_pkg::REG_FIXED_OFFSET: cfg_q.fixed_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/gosos_mult.sv =====
// First pipeline stage: alpha and beta products and offset selection.
// Depends on gosos_pkg.
module gosos_mult (
	input  logic                                 clk,
	input  logic                                 en,
	input  gosos_pkg::cfg_t                      cfg,
	input  logic signed [gosos_pkg::DATA_W-1:0]  accumulator,
	input  logic signed [gosos_pkg::DATA_W-1:0]  prior_value,
	input  logic signed [gosos_pkg::DATA_W-1:0]  vector_offset,
	input  logic                                 is_last,
	output logic signed [gosos_pkg::PROD_W-1:0]  alpha_prod_s1,
	output logic signed [gosos_pkg::PROD_W-1:0]  beta_prod_s1,
	output logic signed [gosos_pkg::DATA_W-1:0]  offset_s1,
	output logic                                 last_s1
);

	localparam int PROD_W = gosos_pkg::PROD_W;

	logic signed [gosos_pkg::DATA_W-1:0] offset_sel;

	always_comb begin
		unique case (cfg.offset_mode)
			gosos_pkg::OFS_FIXED: offset_sel = cfg.fixed_offset;
			gosos_pkg::OFS_COL,
			gosos_pkg::OFS_ROW:   offset_sel = vector_offset;
			default:              offset_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_prod_s1 <= PROD_W'(signed'(cfg.alpha_scale)) * PROD_W'(accumulator);
			beta_prod_s1  <= PROD_W'(signed'(cfg.beta_scale)) * PROD_W'(prior_value);
			offset_s1     <= offset_sel;
			last_s1       <= is_last;
		end
	end

endmodule

// ===== hdl/gosos_round.sv =====
// Second and third stages: exact wide sum, then round half to even and
// clamp to int32 into the result register. Depends on gosos_pkg.
module gosos_round (
	input  logic                                 clk,
	input  logic                                 en_s2,
	input  logic                                 en_s3,
	input  logic signed [gosos_pkg::PROD_W-1:0]  alpha_prod_s1,
	input  logic signed [gosos_pkg::PROD_W-1:0]  beta_prod_s1,
	input  logic signed [gosos_pkg::DATA_W-1:0]  offset_s1,
	input  logic                                 last_s1,
	output logic signed [gosos_pkg::DATA_W-1:0]  result_s3,
	output logic                                 last_s3
);

	localparam int SUM_W  = gosos_pkg::SUM_W;
	localparam int QUOT_W = gosos_pkg::QUOT_W;
	localparam int FRAC_BITS = gosos_pkg::FRAC_BITS;
	localparam int DATA_W = gosos_pkg::DATA_W;

	logic signed [SUM_W-1:0]   sum_s2;
	logic                      last_s2;
	logic signed [SUM_W-1:0]   offset_term;
	logic signed [QUOT_W-1:0]  quot;
	logic [FRAC_BITS-1:0]      frac;
	logic                      round_up;
	logic signed [QUOT_W:0]    rounded;
	logic signed [DATA_W-1:0]  clamped;

	localparam logic signed [QUOT_W:0] MAX_Q =
		(QUOT_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
	localparam logic signed [QUOT_W:0] MIN_Q =
		(QUOT_W+1)'(signed'({1'b1, {(DATA_W-1){1'b0}}}));

	// offset scaled up to the fixed-point grid of the products
	assign offset_term = SUM_W'(signed'({offset_s1, {FRAC_BITS{1'b0}}}));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2  <= SUM_W'(alpha_prod_s1) + SUM_W'(beta_prod_s1) + offset_term;
			last_s2 <= last_s1;
		end
	end

	// floor quotient plus fraction; tie goes to the even quotient
	assign quot     = sum_s2[SUM_W-1:FRAC_BITS];
	assign frac     = sum_s2[FRAC_BITS-1:0];
	assign round_up = (frac > {1'b1, {(FRAC_BITS-1){1'b0}}}) ||
	                  ((frac == {1'b1, {(FRAC_BITS-1){1'b0}}}) && quot[0]);
	assign rounded  = (QUOT_W+1)'(quot) + (QUOT_W+1)'({1'b0, round_up});

	always_comb begin
		if (rounded > MAX_Q)
			clamped = MAX_Q[DATA_W-1:0];
		else if (rounded < MIN_Q)
			clamped = MIN_Q[DATA_W-1:0];
		else
			clamped = rounded[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			result_s3 <= clamped;
			last_s3   <= last_s2;
		end
	end

endmodule

// ===== hdl/gemm_output_scale_offset_saturate.sv =====
// GEMM output stage: result = round_half_even((alpha*acc + beta*prior +
// offset*2^16) / 2^16), clamped to int32; alpha and beta are signed Q15.16.
// Three-stage pipeline (products, wide sum, round/clamp into the output
// register) accepting one beat per cycle while m_tready does not stall the
// output register. Depends on gosos_pkg.
module gemm_output_scale_offset_saturate (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [gosos_pkg::IDX_W-1:0]       cfg_index,
	input  logic [gosos_pkg::DATA_W-1:0]      cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [3*gosos_pkg::DATA_W-1:0]    s_tdata,  // accumulator, prior_value, vector_offset
	input  logic                              s_tlast,  // is_last
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gosos_pkg::DATA_W-1:0]      m_tdata,  // result_value
	output logic                              m_tlast   // last
);

	localparam int DATA_W = gosos_pkg::DATA_W;

	gosos_pkg::cfg_t cfg;

	logic signed [gosos_pkg::PROD_W-1:0] alpha_prod_s1;
	logic signed [gosos_pkg::PROD_W-1:0] beta_prod_s1;
	logic signed [DATA_W-1:0]            offset_s1;
	logic                                last_s1;
	logic signed [DATA_W-1:0]            result_s3;
	logic                                last_s3;

	logic valid_s1, valid_s2, valid_s3;
	logic load_s1, load_s2, load_s3;

	// a stage loads when it is empty or its content moves on this cycle
	assign load_s3  = !valid_s3 || m_tready;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= s_tvalid;
			if (load_s2)
				valid_s2 <= valid_s1;
			if (load_s3)
				valid_s3 <= valid_s2;
		end
	end

	gosos_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gosos_mult u_mult (
		.clk           (clk),
		.en            (load_s1 && s_tvalid),
		.cfg           (cfg),
		.accumulator   (s_tdata[DATA_W-1:0]),
		.prior_value   (s_tdata[2*DATA_W-1:DATA_W]),
		.vector_offset (s_tdata[3*DATA_W-1:2*DATA_W]),
		.is_last       (s_tlast),
		.alpha_prod_s1 (alpha_prod_s1),
		.beta_prod_s1  (beta_prod_s1),
		.offset_s1     (offset_s1),
		.last_s1       (last_s1)
	);

	gosos_round u_round (
		.clk           (clk),
		.en_s2         (load_s2 && valid_s1),
		.en_s3         (load_s3 && valid_s2),
		.alpha_prod_s1 (alpha_prod_s1),
		.beta_prod_s1  (beta_prod_s1),
		.offset_s1     (offset_s1),
		.last_s1       (last_s1),
		.result_s3     (result_s3),
		.last_s3       (last_s3)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = result_s3;
	assign m_tlast  = last_s3;

endmodule
